// ----- rtl/hfla_pkg.sv -----
// Shared types and constants of the handle free-list allocator.
package hfla_pkg;

  localparam int HANDLE_W = 7;
  localparam int PAY_W    = 32;
  localparam int CNT_W    = 7;

  localparam logic [HANDLE_W-1:0] NULL_LINK = '1;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_ASSIGN = 2'd1,
    REQ_FREE   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_STATE = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    ES_FREE     = 2'd0,
    ES_ASSIGNED = 2'd1,
    ES_USED     = 2'd2
  } entry_state_t;

  // One entry of the handle table: its state and its free-list link.
  typedef struct packed {
    entry_state_t        state;
    logic [HANDLE_W-1:0] link;
  } meta_t;

endpackage

// ----- rtl/hfla_table.sv -----
// Handle table memories: entry state with link, entry payload, reset valid bits.
module hfla_table import hfla_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_idx,
  output meta_t            rd_meta,
  output logic [PAY_W-1:0] rd_payload,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_idx,
  input  meta_t            wr_meta,
  input  logic             pay_we,
  input  logic [PAY_W-1:0] wr_payload
);

  localparam logic [HANDLE_W-1:0] LAST_IDX = HANDLE_W'(CAPACITY - 1);

  meta_t              meta_mem [CAPACITY];
  logic [PAY_W-1:0]   pay_mem  [CAPACITY];
  logic [CAPACITY-1:0] vld_r;

  meta_t              meta_q_r;
  logic [PAY_W-1:0]   pay_q_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;

  logic [HANDLE_W-1:0] idx_w;
  logic [HANDLE_W-1:0] dflt_link;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      meta_q_r <= meta_mem[rd_idx];
      pay_q_r  <= pay_mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
      rd_idx_r <= rd_idx;
    end
    if (wr_en) begin
      meta_mem[wr_idx] <= wr_meta;
    end
    if (pay_we) begin
      pay_mem[wr_idx] <= wr_payload;
    end
  end

  // Valid bits: an entry never written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_comb begin
    idx_w     = HANDLE_W'(rd_idx_r);
    dflt_link = (idx_w == LAST_IDX) ? NULL_LINK : idx_w + HANDLE_W'(1);
    if (rd_vld_r) begin
      rd_meta = meta_q_r;
    end else begin
      rd_meta.state = ES_FREE;
      rd_meta.link  = dflt_link;
    end
  end

  assign rd_payload = pay_q_r;

endmodule

// ----- rtl/handle_free_list_allocator.sv -----
// Top level of the LIFO free-list handle allocator.
// An accepted request has its table read registered, then its result registered in execute.
// A new request is taken only after the last has executed, as each table read is followed
//   by its write-back; the free head and counts from one request feed the next request's read.
// A result waiting on out_ready holds the write-back of the request behind it.
// Reset (rst_n low, synchronous) frees all handles, linked 0 upward; no clearing pass.
module handle_free_list_allocator import hfla_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [PAY_W-1:0]    in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic [PAY_W-1:0]    out_result_payload,
  output logic [CNT_W-1:0]    out_free_count,
  output logic [CNT_W-1:0]    out_assigned_count,
  output logic [CNT_W-1:0]    out_used_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [HANDLE_W-1:0] CAP_H   = HANDLE_W'(CAPACITY);
  localparam logic [CNT_W-1:0]    CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  fsm_t                state_r;
  req_e_t              req_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PAY_W-1:0]    payload_r;

  logic [HANDLE_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    free_total_r, free_total_nxt;
  logic [CNT_W-1:0]    asg_total_r, asg_total_nxt;
  logic [CNT_W-1:0]    used_total_r, used_total_nxt;

  logic                out_valid_r;
  status_e_t           out_status_r, status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, rh_nxt;
  logic [PAY_W-1:0]    out_payload_r, rp_nxt;

  // Table port signals
  logic                in_fire;
  logic                exec_go;
  logic [AW-1:0]       rd_idx;
  meta_t               rd_meta;
  logic [PAY_W-1:0]    rd_payload;
  logic                wr_req;
  logic [AW-1:0]       wr_idx;
  meta_t               wr_meta;
  logic                pay_req;
  logic                alloc_full;
  logic                range_bad;

  // Accept only between requests; the next read sees the last write-back.
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Execute once the output register is free or being drained this cycle.
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Allocate reads the entry at the free head, everything else the named handle.
  assign rd_idx = (req_e_t'(in_req_type) == REQ_ALLOC) ? free_head_r[AW-1:0]
                                                       : in_handle[AW-1:0];

  hfla_table #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_fire),
    .rd_idx     (rd_idx),
    .rd_meta    (rd_meta),
    .rd_payload (rd_payload),
    .wr_en      (wr_req && exec_go),
    .wr_idx     (wr_idx),
    .wr_meta    (wr_meta),
    .pay_we     (pay_req && exec_go),
    .wr_payload (payload_r)
  );

  assign alloc_full = (free_total_r == '0) || (free_head_r >= CAP_H);
  assign range_bad  = (handle_r >= CAP_H);

  // Modify step: decide status, table write-back and the new head and counts.
  always_comb begin
    status_nxt     = STAT_OK;
    rh_nxt         = handle_r;
    rp_nxt         = '0;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    asg_total_nxt  = asg_total_r;
    used_total_nxt = used_total_r;
    wr_req         = 1'b0;
    pay_req        = 1'b0;
    wr_idx         = handle_r[AW-1:0];
    wr_meta        = rd_meta;

    if (req_r == REQ_ALLOC) begin
      if (alloc_full) begin
        status_nxt = STAT_FULL;
      end else begin
        // Pop the head: it moves to its link, the entry becomes assigned.
        free_head_nxt  = rd_meta.link;
        wr_req         = 1'b1;
        wr_idx         = free_head_r[AW-1:0];
        wr_meta.state  = ES_ASSIGNED;
        free_total_nxt = free_total_r - CNT_W'(1);
        asg_total_nxt  = asg_total_r + CNT_W'(1);
        rh_nxt         = free_head_r;
      end
    end else if (range_bad) begin
      status_nxt = STAT_RANGE;
    end else begin
      case (req_r)
        REQ_ASSIGN: begin
          if (rd_meta.state != ES_ASSIGNED) begin
            status_nxt = STAT_STATE;
          end else begin
            wr_req         = 1'b1;
            pay_req        = 1'b1;
            wr_meta.state  = ES_USED;
            asg_total_nxt  = asg_total_r - CNT_W'(1);
            used_total_nxt = used_total_r + CNT_W'(1);
          end
        end
        REQ_FREE: begin
          if (rd_meta.state == ES_ASSIGNED || rd_meta.state == ES_USED) begin
            if (rd_meta.state == ES_ASSIGNED) begin
              asg_total_nxt = asg_total_r - CNT_W'(1);
            end else begin
              used_total_nxt = used_total_r - CNT_W'(1);
            end
            // Push onto the head; an empty list ends with the null link.
            wr_req         = 1'b1;
            wr_meta.state  = ES_FREE;
            wr_meta.link   = (free_total_r == '0) ? NULL_LINK : free_head_r;
            free_head_nxt  = handle_r;
            free_total_nxt = free_total_r + CNT_W'(1);
          end else begin
            status_nxt = STAT_STATE;
          end
        end
        REQ_LOOKUP: begin
          if (rd_meta.state != ES_USED) begin
            status_nxt = STAT_STATE;
          end else begin
            rp_nxt = rd_payload;
          end
        end
        default: begin
          status_nxt = STAT_STATE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_head_r  <= '0;
      free_total_r <= CAP_CNT;
      asg_total_r  <= '0;
      used_total_r <= '0;
    end else begin
      // Load a new result, or drop the one taken; both may meet in one cycle.
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r       <= S_IDLE;
            free_head_r   <= free_head_nxt;
            free_total_r  <= free_total_nxt;
            asg_total_r   <= asg_total_nxt;
            used_total_r  <= used_total_nxt;
            out_status_r  <= status_nxt;
            out_handle_r  <= rh_nxt;
            out_payload_r <= rp_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r     <= req_e_t'(in_req_type);
      handle_r  <= in_handle;
      payload_r <= in_payload;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_handle  = out_handle_r;
  assign out_result_payload = out_payload_r;
  assign out_free_count     = free_total_r;
  assign out_assigned_count = asg_total_r;
  assign out_used_count     = used_total_r;

`ifndef SYNTHESIS
  // The free, assigned and used counts always add up to the capacity.
  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({2'b00, free_total_r} + {2'b00, asg_total_r} + {2'b00, used_total_r})
      == (CNT_W + 2)'(CAPACITY))
    else $error("state counts do not add up to the capacity");

  // An empty free list is exactly a head past the table.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (free_total_r == '0) == (free_head_r >= CAP_H))
    else $error("free head disagrees with free count");

  // The table is written only while a request executes.
  a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_req && exec_go) |-> (state_r == S_EXEC && !in_ready))
    else $error("table write outside of execute");
`endif

endmodule
